/* rtl/core/csdc_pkg.sv */
// Shared constants, widths and sequencer states for the centroid step block.
// No dependencies; every rtl/core module refers to it by scoped names.
package csdc_pkg;

  localparam int COORD_W     = 32;                // Q16.16 coordinate
  localparam int FRAC_BITS   = 16;
  localparam int NUM_AXES    = 3;
  localparam int SUM_W       = 41;                // 256 coordinates plus sign
  localparam int CNT_W       = 9;                 // holds 0..MAX_ITEMS
  localparam int MAX_ITEMS   = 256;               // own position plus 255 neighbors
  localparam int DIFF_W      = 33;                // mean minus own position
  localparam int MAG_W       = 32;                // magnitude of a difference
  localparam int PROD_W      = 64;                // 32 x 32 product
  localparam int SQ_W        = 66;                // sum of three squares
  localparam int ROOT_W      = 33;                // floor square root of SQ_W bits
  localparam int DIVD_W      = 64;                // divider dividend
  localparam int DIVS_W      = 33;                // divider divisor
  localparam int DECAY_MUL   = 9;
  localparam int DECAY_DIV   = 10;

  localparam logic [COORD_W-1:0] LIMIT_RESET = COORD_W'(1) << FRAC_BITS;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MEAN,
    ST_SQR,
    ST_LSQ,
    ST_ROOT,
    ST_SCL_MUL,
    ST_SCL_DIV,
    ST_DECAY,
    ST_EMIT
  } cs_state_t;

endpackage

/* rtl/core/csdc_div.sv */
// Radix-2 restoring divider, one quotient bit per cycle, unsigned.
// Depends on csdc_pkg for the dividend and divisor widths.
module csdc_div (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [csdc_pkg::DIVD_W-1:0]       dividend,
  input  logic [csdc_pkg::DIVS_W-1:0]       divisor,
  output logic [csdc_pkg::DIVD_W-1:0]       quotient,
  output logic                              done
);

  localparam int CW = $clog2(csdc_pkg::DIVD_W);

  logic                             busy;
  logic [CW-1:0]                    cnt;
  logic [csdc_pkg::DIVS_W-1:0]      dsr;
  logic [csdc_pkg::DIVS_W-1:0]      rem;
  logic [csdc_pkg::DIVD_W-1:0]      quo;
  logic [csdc_pkg::DIVS_W:0]        shifted;
  logic [csdc_pkg::DIVS_W+1:0]      diff;

  // trial subtract of the divisor from the partial remainder
  always_comb begin
    shifted = {rem, quo[csdc_pkg::DIVD_W-1]};
    diff    = {1'b0, shifted} - {2'b00, dsr};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CW'(1);
        if (cnt == CW'(csdc_pkg::DIVD_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // remainder and quotient shift register
  always_ff @(posedge clk) begin
    if (start) begin
      dsr <= divisor;
      rem <= '0;
      quo <= dividend;
    end else if (busy) begin
      if (!diff[csdc_pkg::DIVS_W+1]) begin
        rem <= diff[csdc_pkg::DIVS_W-1:0];
      end else begin
        rem <= shifted[csdc_pkg::DIVS_W-1:0];
      end
      quo <= {quo[csdc_pkg::DIVD_W-2:0], ~diff[csdc_pkg::DIVS_W+1]};
    end
  end

  assign quotient = quo;

endmodule

/* rtl/core/csdc_mul.sv */
// Shift-and-add multiplier, one multiplier bit per cycle, 32 x 32 unsigned.
// Depends on csdc_pkg for operand and product widths.
module csdc_mul (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [csdc_pkg::MAG_W-1:0]        op_a,
  input  logic [csdc_pkg::MAG_W-1:0]        op_b,
  output logic [csdc_pkg::PROD_W-1:0]       product,
  output logic                              done
);

  localparam int W  = csdc_pkg::MAG_W;
  localparam int CW = $clog2(W);

  logic              busy;
  logic [CW-1:0]     cnt;
  logic [W-1:0]      mcand;
  logic [2*W-1:0]    acc;
  logic [W:0]        psum;

  // add the multiplicand into the upper half when the low bit is set
  always_comb begin
    psum = {1'b0, acc[2*W-1:W]} + (acc[0] ? {1'b0, mcand} : '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CW'(1);
        if (cnt == CW'(W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mcand <= op_b;
      acc   <= {{W{1'b0}}, op_a};
    end else if (busy) begin
      acc <= {psum, acc[W-1:1]};
    end
  end

  assign product = acc;

endmodule

/* rtl/core/csdc_sqrt.sv */
// Digit-by-digit integer square root, one root bit (two radicand bits) per cycle.
// Depends on csdc_pkg for radicand and root widths.
module csdc_sqrt (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [csdc_pkg::SQ_W-1:0]         radicand,
  output logic [csdc_pkg::ROOT_W-1:0]       root,
  output logic                              done
);

  localparam int RW = csdc_pkg::ROOT_W;
  localparam int CW = $clog2(RW);

  logic                         busy;
  logic [CW-1:0]                cnt;
  logic [csdc_pkg::SQ_W-1:0]    rad;
  logic [RW-1:0]                rt;
  logic [RW:0]                  rem;
  logic [RW+2:0]                cur;
  logic [RW+2:0]                trial;
  logic                         fits;

  // bring down two bits and test root*4+1
  always_comb begin
    cur   = {rem, rad[csdc_pkg::SQ_W-1 -: 2]};
    trial = {1'b0, rt, 2'b01};
    fits  = cur >= trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CW'(1);
        if (cnt == CW'(RW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad <= radicand;
      rt  <= '0;
      rem <= '0;
    end else if (busy) begin
      rad <= {rad[csdc_pkg::SQ_W-3:0], 2'b00};
      if (fits) begin
        rem <= (RW+1)'(cur - trial);
        rt  <= {rt[RW-2:0], 1'b1};
      end else begin
        rem <= cur[RW:0];
        rt  <= {rt[RW-2:0], 1'b0};
      end
    end
  end

  assign root = rt;

endmodule

/* rtl/core/centroid_step_with_decaying_clamp.sv */
// Top level: accumulates a set of positions and emits one step per set, clamped to the limit when longer.
// Depends on csdc_pkg, csdc_div, csdc_mul and csdc_sqrt.
//
// Input stream s_axis: one position per item, tlast closes the set; the first
// item of a set is the own position. Non-closing items are accepted without a
// stall and produce nothing. Output stream m_axis: one step per closed set.
// Config: cfg_wr_en with cfg_wr_data loads the step limit at once.
//
// End-of-set work after a closing item runs on bit-serial units: per axis a
// division (mean) and a square, then a limit square and a divide for the
// limit decay. When clamping, a square root and per axis a multiply and a
// divide come before the decay. Input is not taken after the closing item
// until the step is loaded into the output register.
// Reset empties the set and loads the limit with 1.0. A stalled receiver
// holds the finished step in the output register; the next set can be
// accumulated meanwhile, and its result waits until that register frees up.
module centroid_step_with_decaying_clamp (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [95:0]  s_axis_tdata,   // pos_x, pos_y, pos_z
  input  logic         s_axis_tlast,   // last
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [95:0]  m_axis_tdata,   // step_x, step_y, step_z
  output logic [1:0]   m_axis_tuser,   // clamped, overflowed
  input  logic         cfg_wr_en,
  input  logic [31:0]  cfg_wr_data     // initial_limit
);

  localparam int CW = csdc_pkg::COORD_W;
  localparam int SW = csdc_pkg::SUM_W;
  localparam int DW = csdc_pkg::DIFF_W;
  localparam int MW = csdc_pkg::MAG_W;

  csdc_pkg::cs_state_t state, state_next;

  logic signed [SW-1:0]           sums [csdc_pkg::NUM_AXES];
  logic signed [CW-1:0]           own  [csdc_pkg::NUM_AXES];
  logic signed [DW-1:0]           dvec [csdc_pkg::NUM_AXES];
  logic [csdc_pkg::CNT_W-1:0]     count;
  logic [CW-1:0]                  limit;
  logic                           ovf;
  logic [1:0]                     axis;
  logic [csdc_pkg::SQ_W-1:0]      sq;
  logic                           clamp;
  logic [csdc_pkg::ROOT_W-1:0]    nroot;
  logic                           run;

  logic                           in_acc;
  logic signed [CW-1:0]           pos [csdc_pkg::NUM_AXES];

  // unit controls and operands
  logic                           div_start, mul_start, sqrt_start;
  logic                           div_done, mul_done, sqrt_done;
  logic [csdc_pkg::DIVD_W-1:0]    div_dvd, div_q;
  logic [csdc_pkg::DIVS_W-1:0]    div_dvs;
  logic [MW-1:0]                  mul_a, mul_b;
  logic [csdc_pkg::PROD_W-1:0]    mul_p;
  logic [csdc_pkg::ROOT_W-1:0]    sqrt_r;
  logic                           unit_done;

  logic signed [SW-1:0]           sum_sel;
  logic [SW-1:0]                  sum_mag;
  logic signed [DW-1:0]           d_sel;
  logic [MW-1:0]                  d_mag;
  logic signed [SW:0]             mean;
  logic signed [SW:0]             diff_full;
  logic signed [DW-1:0]           scaled;
  logic [35:0]                    lim9;
  logic                           emit_go;

  assign pos[0] = s_axis_tdata[31:0];
  assign pos[1] = s_axis_tdata[63:32];
  assign pos[2] = s_axis_tdata[95:64];

  assign s_axis_tready = (state == csdc_pkg::ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign emit_go       = !m_axis_tvalid || m_axis_tready;

  // operand selection for the current axis
  always_comb begin
    sum_sel   = sums[axis];
    sum_mag   = sum_sel[SW-1] ? SW'(-sum_sel) : SW'(sum_sel);
    d_sel     = dvec[axis];
    d_mag     = d_sel[DW-1] ? MW'(-d_sel) : MW'(d_sel);
    mean      = sum_sel[SW-1] ? -$signed({1'b0, div_q[SW-1:0]})
                              : $signed({1'b0, div_q[SW-1:0]});
    diff_full = mean - (SW+1)'(own[axis]);
    scaled    = d_sel[DW-1] ? -$signed({1'b0, div_q[MW-1:0]})
                            : $signed({1'b0, div_q[MW-1:0]});
    lim9      = ({4'd0, limit} << 3) + {4'd0, limit};
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      csdc_pkg::ST_IDLE: begin
        if (in_acc && s_axis_tlast) state_next = csdc_pkg::ST_MEAN;
      end
      csdc_pkg::ST_MEAN: begin
        if (div_done) state_next = csdc_pkg::ST_SQR;
      end
      csdc_pkg::ST_SQR: begin
        if (mul_done) begin
          state_next = (axis == 2'd2) ? csdc_pkg::ST_LSQ : csdc_pkg::ST_MEAN;
        end
      end
      csdc_pkg::ST_LSQ: begin
        if (mul_done) begin
          state_next = (sq > {2'b00, mul_p}) ? csdc_pkg::ST_ROOT : csdc_pkg::ST_DECAY;
        end
      end
      csdc_pkg::ST_ROOT: begin
        if (sqrt_done) state_next = csdc_pkg::ST_SCL_MUL;
      end
      csdc_pkg::ST_SCL_MUL: begin
        if (mul_done) state_next = csdc_pkg::ST_SCL_DIV;
      end
      csdc_pkg::ST_SCL_DIV: begin
        if (div_done) begin
          state_next = (axis == 2'd2) ? csdc_pkg::ST_DECAY : csdc_pkg::ST_SCL_MUL;
        end
      end
      csdc_pkg::ST_DECAY: begin
        if (div_done) state_next = csdc_pkg::ST_EMIT;
      end
      csdc_pkg::ST_EMIT: begin
        if (emit_go) state_next = csdc_pkg::ST_IDLE;
      end
      default: state_next = csdc_pkg::ST_IDLE;
    endcase
  end

  // unit launches and operands per state
  always_comb begin
    div_start  = 1'b0;
    mul_start  = 1'b0;
    sqrt_start = 1'b0;
    div_dvd    = '0;
    div_dvs    = '0;
    mul_a      = d_mag;
    mul_b      = d_mag;
    unit_done  = 1'b0;
    case (state)
      csdc_pkg::ST_MEAN: begin
        div_start = !run;
        div_dvd   = csdc_pkg::DIVD_W'(sum_mag);
        div_dvs   = csdc_pkg::DIVS_W'(count);
        unit_done = div_done;
      end
      csdc_pkg::ST_SQR: begin
        mul_start = !run;
        unit_done = mul_done;
      end
      csdc_pkg::ST_LSQ: begin
        mul_start = !run;
        mul_a     = limit;
        mul_b     = limit;
        unit_done = mul_done;
      end
      csdc_pkg::ST_ROOT: begin
        sqrt_start = !run;
        unit_done  = sqrt_done;
      end
      csdc_pkg::ST_SCL_MUL: begin
        mul_start = !run;
        mul_b     = limit;
        unit_done = mul_done;
      end
      csdc_pkg::ST_SCL_DIV: begin
        div_start = !run;
        div_dvd   = mul_p;
        div_dvs   = nroot;
        unit_done = div_done;
      end
      csdc_pkg::ST_DECAY: begin
        div_start = !run;
        div_dvd   = csdc_pkg::DIVD_W'(lim9);
        div_dvs   = csdc_pkg::DIVS_W'(csdc_pkg::DECAY_DIV);
        unit_done = div_done;
      end
      default: begin
        unit_done = 1'b0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= csdc_pkg::ST_IDLE;
      run           <= 1'b0;
      count         <= '0;
      ovf           <= 1'b0;
      axis          <= '0;
      limit         <= csdc_pkg::LIMIT_RESET;
      m_axis_tvalid <= 1'b0;
      for (int a = 0; a < csdc_pkg::NUM_AXES; a++) begin
        sums[a] <= '0;
      end
    end else begin
      state <= state_next;
      if (div_start || mul_start || sqrt_start) begin
        run <= 1'b1;
      end else if (unit_done) begin
        run <= 1'b0;
      end

      if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;

      if (cfg_wr_en) limit <= cfg_wr_data;

      case (state)
        csdc_pkg::ST_IDLE: begin
          axis <= '0;
          if (in_acc) begin
            if (count < csdc_pkg::CNT_W'(csdc_pkg::MAX_ITEMS)) begin
              for (int a = 0; a < csdc_pkg::NUM_AXES; a++) begin
                sums[a] <= sums[a] + SW'(pos[a]);
              end
              count <= count + csdc_pkg::CNT_W'(1);
            end else begin
              ovf <= 1'b1;
            end
          end
        end
        csdc_pkg::ST_SQR: begin
          if (mul_done) axis <= (axis == 2'd2) ? 2'd0 : axis + 2'd1;
        end
        csdc_pkg::ST_SCL_DIV: begin
          if (div_done) axis <= (axis == 2'd2) ? 2'd0 : axis + 2'd1;
        end
        csdc_pkg::ST_DECAY: begin
          if (div_done) limit <= div_q[CW-1:0];
        end
        csdc_pkg::ST_EMIT: begin
          if (emit_go) begin
            m_axis_tvalid <= 1'b1;
            count         <= '0;
            ovf           <= 1'b0;
            for (int a = 0; a < csdc_pkg::NUM_AXES; a++) begin
              sums[a] <= '0;
            end
          end
        end
        default: begin
          axis <= axis;
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (state == csdc_pkg::ST_IDLE && in_acc && count == '0) begin
      for (int a = 0; a < csdc_pkg::NUM_AXES; a++) begin
        own[a] <= pos[a];
      end
    end
    if (state == csdc_pkg::ST_IDLE) begin
      sq    <= '0;
      clamp <= 1'b0;
    end
    if (state == csdc_pkg::ST_MEAN && div_done) begin
      dvec[axis] <= diff_full[DW-1:0];
    end
    if (state == csdc_pkg::ST_SQR && mul_done) begin
      sq <= sq + {2'b00, mul_p};
    end
    if (state == csdc_pkg::ST_LSQ && mul_done) begin
      clamp <= sq > {2'b00, mul_p};
    end
    if (state == csdc_pkg::ST_ROOT && sqrt_done) begin
      nroot <= sqrt_r;
    end
    if (state == csdc_pkg::ST_SCL_DIV && div_done) begin
      dvec[axis] <= scaled;
    end
    if (state == csdc_pkg::ST_EMIT && emit_go) begin
      for (int a = 0; a < csdc_pkg::NUM_AXES; a++) begin
        if (dvec[a] > DW'(33'sh0_7FFF_FFFF)) begin
          m_axis_tdata[a*CW +: CW] <= 32'h7FFF_FFFF;
        end else if (dvec[a] < -DW'(33'sh0_8000_0000)) begin
          m_axis_tdata[a*CW +: CW] <= 32'h8000_0000;
        end else begin
          m_axis_tdata[a*CW +: CW] <= dvec[a][CW-1:0];
        end
      end
      m_axis_tuser <= {ovf, clamp};
    end
  end

  csdc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .quotient (div_q),
    .done     (div_done)
  );

  csdc_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .op_a    (mul_a),
    .op_b    (mul_b),
    .product (mul_p),
    .done    (mul_done)
  );

  csdc_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sqrt_start),
    .radicand (sq),
    .root     (sqrt_r),
    .done     (sqrt_done)
  );

endmodule

/* test/tb_top.sv */
// Self-checking testbench for centroid_step_with_decaying_clamp: drives sets of
// positions, predicts each step, clamped where needed, and compares it field by field.
// Depends on csdc_pkg and the rtl/core sources.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic               last;
  } position_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic               clamped;
    logic               overflowed;
  } step_t;

  localparam int MAX_POSITIONS = csdc_pkg::MAX_ITEMS;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [95:0]  s_axis_tdata = '0;
  logic         s_axis_tlast = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [95:0]  m_axis_tdata;
  logic [1:0]   m_axis_tuser;
  logic         cfg_wr_en = 1'b0;
  logic [31:0]  cfg_wr_data = '0;

  centroid_step_with_decaying_clamp dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  always #10 clk = ~clk;

  // predictor state
  logic signed [63:0] acc_x, acc_y, acc_z;
  logic signed [31:0] own_x, own_y, own_z;
  int unsigned        pos_count;
  logic [63:0]        step_limit;
  logic               dropped_seen;

  position_t pending_positions[$];
  step_t     expected_steps[$];
  int        send_idle_pct = 0;
  int        recv_idle_pct = 0;
  bit        failed = 0;
  bit        in_taken = 0;

  function automatic logic [63:0] magnitude(logic signed [63:0] v);
    return v < 0 ? -v : v;
  endfunction

  function automatic logic signed [31:0] saturate(logic signed [63:0] v);
    if (v > 64'sh7FFFFFFF) return 32'h7FFFFFFF;
    if (v < -64'sh80000000) return 32'h80000000;
    return v[31:0];
  endfunction

  // Accumulate one accepted position; push the step on a closing item.
  task automatic predict_position(position_t p);
    logic signed [63:0] d[3];
    logic [127:0]       norm_sq, cand_sq;
    logic [127:0]       root, cand, q;
    logic               clamp;
    if (pos_count < MAX_POSITIONS) begin
      if (pos_count == 0) begin
        own_x = p.x; own_y = p.y; own_z = p.z;
      end
      acc_x += p.x; acc_y += p.y; acc_z += p.z;
      pos_count++;
    end else begin
      dropped_seen = 1'b1;
    end
    if (!p.last) return;
    d[0] = acc_x / $signed(64'(pos_count)) - own_x;
    d[1] = acc_y / $signed(64'(pos_count)) - own_y;
    d[2] = acc_z / $signed(64'(pos_count)) - own_z;
    norm_sq = '0;
    for (int i = 0; i < 3; i++)
      norm_sq += 128'(magnitude(d[i])) * 128'(magnitude(d[i]));
    clamp = norm_sq > 128'(step_limit) * 128'(step_limit);
    if (clamp) begin
      root = '0;
      for (int b = 33; b >= 0; b--) begin
        cand = root | (128'(1) << b);
        cand_sq = cand * cand;
        if (cand_sq <= norm_sq) root = cand;
      end
      for (int i = 0; i < 3; i++) begin
        q = 128'(magnitude(d[i])) * 128'(step_limit) / root;
        d[i] = d[i] < 0 ? -$signed(q[63:0]) : $signed(q[63:0]);
      end
    end
    expected_steps.push_back('{saturate(d[0]), saturate(d[1]), saturate(d[2]),
                               clamp, dropped_seen});
    step_limit = step_limit * 9 / 10;
    acc_x = 0; acc_y = 0; acc_z = 0;
    pos_count = 0;
    dropped_seen = 1'b0;
  endtask

  // input acceptance, sampled on the rising edge
  always @(posedge clk) begin
    in_taken <= !rst && s_axis_tvalid && s_axis_tready;
  end

  // driver: inputs change on the falling edge
  always @(negedge clk) begin
    if (!rst) begin
      if (in_taken) begin
        predict_position('{s_axis_tdata[31:0], s_axis_tdata[63:32],
                           s_axis_tdata[95:64], s_axis_tlast});
        void'(pending_positions.pop_front());
      end
      if (s_axis_tvalid && !in_taken) begin
        // item still waiting: hold it
        s_axis_tvalid <= 1'b1;
      end else if (pending_positions.size() > 0 &&
                   $urandom_range(99) >= send_idle_pct) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {pending_positions[0].z, pending_positions[0].y,
                          pending_positions[0].x};
        s_axis_tlast  <= pending_positions[0].last;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
      m_axis_tready <= $urandom_range(99) >= recv_idle_pct;
    end
  end

  // monitor: sample on the rising edge
  always @(posedge clk) begin
    step_t got, want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = '{m_axis_tdata[31:0], m_axis_tdata[63:32], m_axis_tdata[95:64],
              m_axis_tuser[0], m_axis_tuser[1]};
      if (expected_steps.size() == 0) begin
        $error("unexpected step x=%0d y=%0d z=%0d", got.x, got.y, got.z);
        failed = 1;
      end else begin
        want = expected_steps.pop_front();
        if (got.x !== want.x) begin
          $error("step_x expected %0d got %0d", want.x, got.x); failed = 1;
        end
        if (got.y !== want.y) begin
          $error("step_y expected %0d got %0d", want.y, got.y); failed = 1;
        end
        if (got.z !== want.z) begin
          $error("step_z expected %0d got %0d", want.z, got.z); failed = 1;
        end
        if (got.clamped !== want.clamped) begin
          $error("clamped expected %0d got %0d", want.clamped, got.clamped); failed = 1;
        end
        if (got.overflowed !== want.overflowed) begin
          $error("overflowed expected %0d got %0d", want.overflowed, got.overflowed);
          failed = 1;
        end
      end
    end
  end

  function automatic logic [31:0] rand_coord(int mode);
    case (mode)
      0: return $urandom();
      1: return $urandom_range(32'h0004_0000) - 32'h0002_0000;
      2: return $urandom_range(1) ? 32'h7FFFFFFF : 32'h80000000;
      default: return $urandom_range(255) - 128;
    endcase
  endfunction

  task automatic queue_set(int n, int mode);
    position_t p;
    for (int i = 0; i < n; i++) begin
      p.x = rand_coord(mode); p.y = rand_coord(mode); p.z = rand_coord(mode);
      p.last = (i == n - 1);
      pending_positions.push_back(p);
    end
  endtask

  task automatic queue_fixed(logic [31:0] x, logic [31:0] y, logic [31:0] z, bit last);
    pending_positions.push_back('{x, y, z, last});
  endtask

  // wait for drain, then let the block finish before a limit write
  task automatic drain_and_write(logic [31:0] value);
    wait (pending_positions.size() == 0 && expected_steps.size() == 0);
    repeat (1000) @(posedge clk);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    step_limit = value;
  endtask

  task automatic random_sets(int items);
    int sent, n, mode;
    sent = 0;
    while (sent < items) begin
      n = ($urandom_range(19) == 0) ? $urandom_range(300, 256) : $urandom_range(8, 1);
      mode = $urandom_range(3);
      queue_set(n, mode);
      sent += n;
      if ($urandom_range(29) == 0) begin
        drain_and_write($urandom_range(3) == 0 ? $urandom() : $urandom_range(32'h0010_0000));
      end
      wait (pending_positions.size() < 20);
    end
  endtask

  initial begin
    acc_x = 0; acc_y = 0; acc_z = 0;
    own_x = 0; own_y = 0; own_z = 0;
    pos_count = 0; dropped_seen = 0;
    step_limit = csdc_pkg::LIMIT_RESET;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: single-item set, zero vector, extremes, saturation, zero limit, overflow
    send_idle_pct = 37; recv_idle_pct = 55;
    queue_fixed(32'h12345678, 32'h80000000, 32'h7FFFFFFF, 1'b1);
    queue_fixed(32'h100, 32'h200, 32'h300, 1'b0);
    queue_fixed(32'h100, 32'h200, 32'h300, 1'b1);
    queue_fixed(32'h0, 32'h0, 32'h0, 1'b0);
    queue_fixed(32'h8000, 32'hFFFF8000, 32'h0, 1'b1);
    queue_fixed(32'h0, 32'h0, 32'h0, 1'b0);
    queue_fixed(32'h1, 32'hFFFFFFFF, 32'h3, 1'b0);
    queue_fixed(32'hFFFFFFFE, 32'h5, 32'hFFFFFFF9, 1'b1);
    drain_and_write(32'hFFFFFFFF);
    queue_fixed(32'h80000000, 32'h80000000, 32'h80000000, 1'b0);
    queue_fixed(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 1'b1);
    queue_fixed(32'h7FFFFFFF, 32'h80000000, 32'h0, 1'b0);
    queue_fixed(32'h80000000, 32'h7FFFFFFF, 32'h0, 1'b1);
    drain_and_write(32'h0);
    queue_fixed(32'h0, 32'h0, 32'h0, 1'b0);
    queue_fixed(32'h10000, 32'hFFFF0000, 32'h5, 1'b1);
    queue_fixed(32'h0, 32'h0, 32'h0, 1'b0);
    queue_fixed(32'h0, 32'h0, 32'h0, 1'b1);
    drain_and_write(32'h0001_0000);
    queue_set(258, 1);

    random_sets(420);
    drain_and_write($urandom());
    send_idle_pct = 55; recv_idle_pct = 37;
    random_sets(420);
    drain_and_write($urandom_range(32'h0008_0000));
    send_idle_pct = 0; recv_idle_pct = 0;
    random_sets(420);

    wait (pending_positions.size() == 0 && expected_steps.size() == 0);
    repeat (1000) @(posedge clk);
    if (!failed)
      $display("centroid_step_with_decaying_clamp regression: pass");
    else
      $display("centroid_step_with_decaying_clamp regression: fail");
    $finish;
  end

  initial begin
    #200ms;
    $display("centroid_step_with_decaying_clamp regression: fail");
    $finish;
  end
endmodule

/* files.f */
rtl/core/csdc_pkg.sv
rtl/core/csdc_div.sv
rtl/core/csdc_mul.sv
rtl/core/csdc_sqrt.sv
rtl/core/centroid_step_with_decaying_clamp.sv
test/tb_top.sv
